/* hw/rtl/rrts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = 64;
    localparam int STRIDE_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STACK_BYTES = 8192;

    localparam logic [ADDR_W-1:0]   STACK_BYTES_V = ADDR_W'(STACK_BYTES);
    localparam logic [ADDR_W-1:0]   BASE_RESET    = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 16'd8312;

    localparam logic [CFG_IDX_W-1:0] REG_STACK_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 2'd1;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_YIELD    = 2'd1;
    localparam logic [1:0] OP_EXIT     = 2'd2;
    localparam logic [1:0] OP_SCHEDULE = 2'd3;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_RUNNING  = 2'd1;
    localparam logic [1:0] SLOT_RUNNABLE = 2'd2;

    localparam logic [2:0] STS_NO_SWITCH  = 3'd0;
    localparam logic [2:0] STS_SWITCHED   = 3'd1;
    localparam logic [2:0] STS_HALT       = 3'd2;
    localparam logic [2:0] STS_CREATED    = 3'd3;
    localparam logic [2:0] STS_TABLE_FULL = 3'd4;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] outgoing_return;
        logic [ADDR_W-1:0] outgoing_stack;
    } t_rrts_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] from_slot;
        logic [SLOT_W-1:0] to_slot;
        logic [ADDR_W-1:0] resume_address;
        logic [ADDR_W-1:0] resume_stack;
    } t_rrts_out;

endpackage

`default_nettype wire

/* hw/rtl/round_robin_thread_scheduler.sv */
// Channel  | Direction | Handshake                  | Payload
// in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_rrts_in)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (t_rrts_out)
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item is taken in and its scan then visits up to four slots, one slot per cycle
// while the output register is free, through a single slot probe and a single 64-bit
// adder that also builds the stack top.
// Reset leaves slot zero running and current, all other slots free.
// A finished result sits in the output register; the scan pauses on any step while
// that register is still occupied. Configuration transfers are always taken.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler
    import rrts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_rrts_in             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_rrts_out                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [1:0]          r_slot_st [SLOTS];
    logic [SLOT_W-1:0]   r_cur;
    logic [SLOT_W-1:0]   r_from;
    logic [SLOT_W-1:0]   r_probe;
    logic [SLOT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]   r_acc;
    t_rrts_in            r_in;
    logic                r_out_valid;
    t_rrts_out           r_out;

    logic [ADDR_W-1:0]   r_mem_ret [SLOTS];
    logic [ADDR_W-1:0]   r_mem_stk [SLOTS];

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_create;
    logic                w_hit;
    logic                w_last;
    logic                w_step;
    logic                w_finish;
    logic [SLOT_W-1:0]   n_probe;
    logic [ADDR_W-1:0]   w_add_a;
    logic [ADDR_W-1:0]   w_add_b;
    logic [ADDR_W-1:0]   w_sum;
    logic                w_mem_we;
    logic [SLOT_W-1:0]   w_mem_addr;
    logic [ADDR_W-1:0]   w_mem_ret_d;
    logic [ADDR_W-1:0]   w_mem_stk_d;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_create   = (r_in.operation == OP_CREATE);
    assign w_hit      = w_create ? (r_slot_st[r_probe] == SLOT_FREE)
                                 : (r_slot_st[r_probe] == SLOT_RUNNABLE);
    assign w_last     = (r_cnt == SLOT_W'(SLOTS - 1));
    assign w_step     = (r_state == S_SCAN) && w_out_free;
    assign w_finish   = w_step && (w_hit || w_last);
    assign n_probe    = (r_probe == SLOT_W'(SLOTS - 1)) ? '0 : r_probe + 1'b1;

    // Shared adder: base plus stack size on entry, then one stride per skipped slot.
    assign w_add_a = (r_state == S_IDLE) ? r_base : r_acc;
    assign w_add_b = (r_state == S_IDLE) ? STACK_BYTES_V : {{(ADDR_W-STRIDE_W){1'b0}}, r_stride};
    assign w_sum   = w_add_a + w_add_b;

    assign w_mem_we    = w_step && w_hit && (w_create || (r_probe != r_from));
    assign w_mem_addr  = w_create ? r_probe : r_from;
    assign w_mem_ret_d = w_create ? r_in.entry_address : r_in.outgoing_return;
    assign w_mem_stk_d = w_create ? r_acc : r_in.outgoing_stack;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_ret[w_mem_addr] <= w_mem_ret_d;
            r_mem_stk[w_mem_addr] <= w_mem_stk_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_RESET;
            r_stride    <= STRIDE_RESET;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_st[i] <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_STACK_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == REG_SLOT_STRIDE) begin
                    r_stride <= i_cfg_data[STRIDE_W-1:0];
                end
            end
            if (r_out_valid && i_out_ready && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in      <= i_in_data;
                        r_acc     <= w_sum;
                        r_cnt     <= '0;
                        r_state   <= S_SCAN;
                        r_probe   <= (i_in_data.operation == OP_CREATE) ? '0 :
                                     ((r_cur == SLOT_W'(SLOTS - 1)) ? '0 : r_cur + 1'b1);
                        r_from    <= r_cur;
                        if (i_in_data.operation == OP_YIELD) begin
                            r_slot_st[r_cur] <= SLOT_RUNNABLE;
                        end else if (i_in_data.operation == OP_EXIT) begin
                            r_slot_st[r_cur] <= SLOT_FREE;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_step && !w_finish) begin
                        r_probe <= n_probe;
                        r_cnt   <= r_cnt + 1'b1;
                        r_acc   <= w_sum;
                    end
                    if (w_finish) begin
                        r_state         <= S_IDLE;
                        r_out_valid     <= 1'b1;
                        r_out.from_slot <= r_from;
                        if (w_create) begin
                            if (w_hit) begin
                                r_slot_st[r_probe]   <= SLOT_RUNNABLE;
                                r_out.status         <= STS_CREATED;
                                r_out.to_slot        <= r_probe;
                                r_out.resume_address <= r_in.entry_address;
                                r_out.resume_stack   <= r_acc;
                            end else begin
                                r_out.status         <= STS_TABLE_FULL;
                                r_out.to_slot        <= '0;
                                r_out.resume_address <= '0;
                                r_out.resume_stack   <= '0;
                            end
                        end else if (!w_hit) begin
                            r_out.status         <= STS_HALT;
                            r_out.to_slot        <= '0;
                            r_out.resume_address <= '0;
                            r_out.resume_stack   <= '0;
                        end else if (r_probe == r_from) begin
                            r_out.status         <= STS_NO_SWITCH;
                            r_out.to_slot        <= r_probe;
                            r_out.resume_address <= '0;
                            r_out.resume_stack   <= '0;
                        end else begin
                            r_slot_st[r_probe]   <= SLOT_RUNNING;
                            r_cur                <= r_probe;
                            r_out.status         <= STS_SWITCHED;
                            r_out.to_slot        <= r_probe;
                            r_out.resume_address <= r_mem_ret[r_probe];
                            r_out.resume_stack   <= r_mem_stk[r_probe];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("scheduler took a transfer while a scan was running");

    a_switch_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_SWITCHED) |-> (r_out.to_slot != r_out.from_slot))
        else $error("switch reported to the outgoing slot");

    a_switch_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && !w_create && w_hit && r_probe != r_from)
        |=> (r_cur == $past(r_probe)) && (r_slot_st[r_cur] == SLOT_RUNNING))
        else $error("incoming slot not made current and running");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STS_HALT || r_out.status == STS_TABLE_FULL))
        |-> (r_out.to_slot == '0 && r_out.resume_address == '0 && r_out.resume_stack == '0))
        else $error("halt or table full result carries slot data");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_finish) |=> (r_state == S_SCAN) && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("scan counter did not advance");
`endif

endmodule

`default_nettype wire

/* tb/round_robin_thread_scheduler_tb.sv */
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb
    import rrts_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [ADDR_W-1:0]    ALL_ONES     = '1;
    localparam logic [ADDR_W-1:0]    ALL_ZEROS    = '0;
    localparam int MAX_GAP       = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int BURST_ITEMS   = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 82;
    localparam int PHASES        = 5;
    localparam int TAIL_ITEMS    = 8;

    class slot_table_tracker;
        logic [1:0]          slot_state[SLOTS];
        logic [ADDR_W-1:0]   saved_ra[SLOTS];
        logic [ADDR_W-1:0]   saved_sp[SLOTS];
        logic [SLOT_W-1:0]   cur;
        logic [ADDR_W-1:0]   base;
        logic [STRIDE_W-1:0] stride;
        t_rrts_out           pending_outcomes[$];
        int                  errors;
        int                  requests;
        int                  replies;
        int                  reg_writes;
        int                  by_status[8];

        function new();
            int s;
            for (s = 0; s < SLOTS; s++) begin
                slot_state[s] = SLOT_FREE;
                saved_ra[s]   = '0;
                saved_sp[s]   = '0;
            end
            for (s = 0; s < 8; s++) begin
                by_status[s] = 0;
            end
            slot_state[0] = SLOT_RUNNING;
            cur        = '0;
            base       = BASE_RESET;
            stride     = STRIDE_RESET;
            errors     = 0;
            requests   = 0;
            replies    = 0;
            reg_writes = 0;
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                REG_STACK_BASE:  base = value;
                REG_SLOT_STRIDE: stride = value[STRIDE_W-1:0];
                default: ;
            endcase
            reg_writes++;
        endfunction

        function t_rrts_out outcome_of(t_rrts_in it);
            t_rrts_out         r;
            int                s;
            int                probe;
            int                found;
            logic [SLOT_W-1:0] from;
            from        = cur;
            r           = '0;
            r.from_slot = from;
            found       = -1;
            if (it.operation == OP_CREATE) begin
                for (s = 0; s < SLOTS; s++) begin
                    if (found < 0 && slot_state[s] == SLOT_FREE) begin
                        found = s;
                    end
                end
                if (found < 0) begin
                    r.status = STS_TABLE_FULL;
                end else begin
                    slot_state[found] = SLOT_RUNNABLE;
                    saved_ra[found]   = it.entry_address;
                    saved_sp[found]   = base + ADDR_W'(found) * ADDR_W'(stride)
                                        + STACK_BYTES_V;
                    r.status          = STS_CREATED;
                    r.to_slot         = SLOT_W'(found);
                    r.resume_address  = saved_ra[found];
                    r.resume_stack    = saved_sp[found];
                end
                return r;
            end
            if (it.operation == OP_YIELD) begin
                slot_state[from] = SLOT_RUNNABLE;
            end else if (it.operation == OP_EXIT) begin
                slot_state[from] = SLOT_FREE;
            end
            probe = from;
            for (s = 0; s < SLOTS; s++) begin
                probe = (probe + 1) % SLOTS;
                if (found < 0 && slot_state[probe] == SLOT_RUNNABLE) begin
                    found = probe;
                end
            end
            if (found < 0) begin
                r.status = STS_HALT;
            end else if (found == int'(from)) begin
                r.status  = STS_NO_SWITCH;
                r.to_slot = from;
            end else begin
                slot_state[found] = SLOT_RUNNING;
                saved_ra[from]    = it.outgoing_return;
                saved_sp[from]    = it.outgoing_stack;
                cur               = SLOT_W'(found);
                r.status          = STS_SWITCHED;
                r.to_slot         = SLOT_W'(found);
                r.resume_address  = saved_ra[found];
                r.resume_stack    = saved_sp[found];
            end
            return r;
        endfunction

        function void take_request(t_rrts_in it);
            pending_outcomes.push_back(outcome_of(it));
            requests++;
        endfunction

        task check_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            if (got !== want) begin
                log_mismatch($sformatf("reply %0d %s: got %h, expected %h",
                                       replies, name, got, want));
            end
        endtask

        task check_reply(t_rrts_out got);
            t_rrts_out want;
            replies++;
            if (pending_outcomes.size() == 0) begin
                log_mismatch($sformatf("reply %0d arrived with no request waiting", replies));
                return;
            end
            want = pending_outcomes.pop_front();
            by_status[want.status]++;
            check_field("status", ADDR_W'(got.status), ADDR_W'(want.status));
            check_field("from_slot", ADDR_W'(got.from_slot), ADDR_W'(want.from_slot));
            check_field("to_slot", ADDR_W'(got.to_slot), ADDR_W'(want.to_slot));
            check_field("resume_address", got.resume_address, want.resume_address);
            check_field("resume_stack", got.resume_stack, want.resume_stack);
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_rrts_in             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_rrts_out            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    slot_table_tracker tracker;
    bit                sender_idle;
    bit                receiver_idle;
    bit                hold_request;

    round_robin_thread_scheduler DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    function logic [ADDR_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return ALL_ZEROS;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function int sender_gap();
        return sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function t_rrts_in mk_req(logic [1:0] op, logic [ADDR_W-1:0] ea,
                              logic [ADDR_W-1:0] ra, logic [ADDR_W-1:0] sp);
        t_rrts_in it;
        it.operation       = op;
        it.entry_address   = ea;
        it.outgoing_return = ra;
        it.outgoing_stack  = sp;
        return it;
    endfunction

    // A plain schedule is only issued when the current slot is not running, so that
    // no slot is left running behind the current one for the rest of the run.
    function t_rrts_in random_request();
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (tracker.slot_state[tracker.cur] == SLOT_RUNNING) begin
            op = (pick < 35) ? OP_CREATE : (pick < 80) ? OP_YIELD : OP_EXIT;
        end else begin
            op = (pick < 30) ? OP_CREATE : (pick < 80) ? OP_SCHEDULE :
                 (pick < 90) ? OP_YIELD : OP_EXIT;
        end
        return mk_req(op, rand_word(), rand_word(), rand_word());
    endfunction

    task send_request(t_rrts_in it, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.take_request(it);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task drain();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        while (tracker.pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (tracker.pending_outcomes.size() != 0) begin
            tracker.log_mismatch($sformatf("%0d replies never arrived",
                                           tracker.pending_outcomes.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : reply_sink
        int gap;
        out_ready = 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            tracker.check_reply(out_data);
        end
    end

    initial begin : request_source
        int       p;
        int       i;
        t_rrts_in it;
        tracker       = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_STACK_BASE;
        cfg_data      = '0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_request  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through every status, starting from the reset register values.
        send_request(mk_req(OP_SCHEDULE, ALL_ONES, ALL_ONES, ALL_ONES), sender_gap());
        send_request(mk_req(OP_YIELD, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS), sender_gap());
        send_request(mk_req(OP_SCHEDULE, ALL_ONES, ALL_ZEROS, ALL_ONES), sender_gap());
        send_request(mk_req(OP_CREATE, ALL_ZEROS, ALL_ONES, ALL_ONES), sender_gap());
        send_request(mk_req(OP_CREATE, ALL_ONES, ALL_ZEROS, ALL_ZEROS), sender_gap());
        send_request(mk_req(OP_CREATE, rand_word(), rand_word(), rand_word()), sender_gap());
        send_request(mk_req(OP_CREATE, ALL_ONES, ALL_ONES, ALL_ONES), sender_gap());
        send_request(mk_req(OP_SCHEDULE, ALL_ZEROS, ALL_ONES, ALL_ZEROS), sender_gap());
        send_request(mk_req(OP_YIELD, ALL_ONES, ALL_ZEROS, ALL_ONES), sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), rand_word(), rand_word()), sender_gap());
        send_request(mk_req(OP_YIELD, rand_word(), ALL_ONES, ALL_ONES), sender_gap());
        send_request(mk_req(OP_CREATE, {$urandom, $urandom}, ALL_ZEROS, ALL_ZEROS),
                     sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), {$urandom, $urandom}, ALL_ONES),
                     sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), ALL_ONES, {$urandom, $urandom}),
                     sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), ALL_ZEROS, ALL_ONES), sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), ALL_ONES, ALL_ZEROS), sender_gap());
        send_request(mk_req(OP_YIELD, rand_word(), rand_word(), rand_word()), sender_gap());
        send_request(mk_req(OP_EXIT, rand_word(), rand_word(), rand_word()), sender_gap());
        send_request(mk_req(OP_CREATE, {$urandom, $urandom}, ALL_ONES, ALL_ONES),
                     sender_gap());
        send_request(mk_req(OP_SCHEDULE, rand_word(), {$urandom, $urandom},
                            {$urandom, $urandom}), sender_gap());
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(REG_STACK_BASE, ALL_ONES);
                    write_reg(REG_SLOT_STRIDE, ALL_ONES);
                    sender_idle   = 1'b1;
                    receiver_idle = 1'b1;
                end
                1: begin
                    write_reg(REG_STACK_BASE, ALL_ZEROS);
                    write_reg(REG_SLOT_STRIDE, ALL_ZEROS);
                    sender_idle   = 1'b0;
                    receiver_idle = 1'b0;
                end
                2: begin
                    write_reg(REG_STACK_BASE, {$urandom, $urandom});
                    write_reg(REG_SLOT_STRIDE, {$urandom, $urandom});
                    sender_idle   = 1'b1;
                    receiver_idle = 1'b1;
                    hold_request  = 1'b1;
                    for (i = 0; i < BURST_ITEMS; i++) begin
                        send_request(random_request(), 0);
                    end
                    drain();
                end
                3: begin
                    write_reg(REG_SPARE_LO, {$urandom, $urandom});
                    write_reg(REG_SPARE_HI, {$urandom, $urandom});
                    write_reg(REG_STACK_BASE, {$urandom, $urandom});
                    write_reg(REG_SLOT_STRIDE, 64'd1);
                    sender_idle   = 1'b1;
                    receiver_idle = 1'b0;
                end
                default: begin
                    write_reg(REG_STACK_BASE, {$urandom, $urandom});
                    write_reg(REG_SLOT_STRIDE, {$urandom, $urandom});
                    sender_idle   = 1'b0;
                    receiver_idle = 1'b1;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_request(random_request(), sender_gap());
            end
            drain();
        end

        // Schedule without a yield while the current slot is still running; this leaves
        // slots running behind the current one, so it comes last.
        sender_idle = 1'b1;
        for (i = 0; i < TAIL_ITEMS; i++) begin
            it = mk_req((i % 2 == 0) ? OP_CREATE : OP_SCHEDULE,
                        rand_word(), rand_word(), rand_word());
            send_request(it, sender_gap());
        end
        drain();

        $display("Run covered %0d request transfers, %0d replies, %0d register writes.",
                 tracker.requests, tracker.replies, tracker.reg_writes);
        $display("Statuses seen: %0d switched, %0d no switch, %0d halt, %0d created, %0d full.",
                 tracker.by_status[STS_SWITCHED], tracker.by_status[STS_NO_SWITCH],
                 tracker.by_status[STS_HALT], tracker.by_status[STS_CREATED],
                 tracker.by_status[STS_TABLE_FULL]);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
